@@ rtl/core/rsa_pkg.sv @@
// Shared types, constants and codes of the record slot allocator.
package rsa_pkg;

    // File geometry
    localparam int PAGES       = 16;
    localparam int PAGE_W      = 4;
    localparam int PAGE_CNT_W  = $clog2(PAGES + 1);
    localparam int SLOTS       = 32;
    localparam int SLOT_W      = 5;
    localparam int SPP_W       = 6;
    localparam int RECORD_BITS = 64;
    localparam int REC_ADDR_W  = PAGE_W + SLOT_W;
    localparam int REC_DEPTH   = PAGES * SLOTS;

    localparam logic [PAGE_CNT_W-1:0] NO_PAGE   = PAGE_CNT_W'(PAGES);
    localparam logic [SPP_W-1:0]      SPP_RESET = SPP_W'(32);

    // Request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_UPDATE = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_PAGE = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [1:0] STATUS_FULL    = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [3:0]             page_number;
        logic [4:0]             slot_number;
        logic [RECORD_BITS-1:0] record_data;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [3:0]             result_page;
        logic [4:0]             result_slot;
        logic [RECORD_BITS-1:0] read_data;
    } rsp_t;

    // Per-page metadata word
    typedef struct packed {
        logic [PAGE_CNT_W-1:0] next_free;
        logic [SPP_W-1:0]      used_count;
        logic [SLOTS-1:0]      occupancy;
    } meta_t;

    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] addr;
        meta_t             data;
    } meta_wr_t;

    typedef struct packed {
        logic                   en;
        logic [REC_ADDR_W-1:0]  addr;
        logic [RECORD_BITS-1:0] data;
    } rec_wr_t;

endpackage

@@ rtl/core/rsa_meta_ram.sv @@
// Page metadata memory: one write port, one registered read port.
module rsa_meta_ram (
    input  logic                       clk,
    input  rsa_pkg::meta_wr_t          wr,
    input  logic                       rd_en,
    input  logic [rsa_pkg::PAGE_W-1:0] rd_addr,
    output rsa_pkg::meta_t             rd_data
);

    rsa_pkg::meta_t mem [rsa_pkg::PAGES];

    // Write and read the metadata array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/rsa_record_ram.sv @@
// Record word memory: one write port, one registered read port.
module rsa_record_ram (
    input  logic                            clk,
    input  rsa_pkg::rec_wr_t                wr,
    input  logic                            rd_en,
    input  logic [rsa_pkg::REC_ADDR_W-1:0]  rd_addr,
    output logic [rsa_pkg::RECORD_BITS-1:0] rd_data
);

    logic [rsa_pkg::RECORD_BITS-1:0] mem [rsa_pkg::REC_DEPTH];

    // Write and read the record array
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/rsa_slot_find.sv @@
// Lowest clear slot search within the used part of a page.
module rsa_slot_find (
    input  logic [rsa_pkg::SLOTS-1:0]  occupancy,
    input  logic [rsa_pkg::SPP_W-1:0]  spp,
    output logic                       found,
    output logic [rsa_pkg::SLOT_W-1:0] slot
);

    logic [rsa_pkg::SLOTS-1:0] blocked;

    // Block used slots and slots beyond the page size
    always_comb
    begin
        for (int i = 0; i < rsa_pkg::SLOTS; i++)
        begin
            blocked[i] = occupancy[i] | (rsa_pkg::SPP_W'(i) >= spp);
        end
    end

    // Priority-encode the lowest open slot
    always_comb
    begin
        found = 1'b0;
        slot  = '0;
        for (int i = rsa_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!blocked[i])
            begin
                found = 1'b1;
                slot  = rsa_pkg::SLOT_W'(i);
            end
        end
    end

endmodule

@@ rtl/core/record_slot_allocator.sv @@
// Top level of the record slot allocator: control, page list and result register.
//
// Usage:
//   Requests (insert, delete, read, update) transfer on the command channel
//   when start is high and busy is low. The metadata and record memories are
//   read at that edge; the next cycle (busy high) checks the request, for an
//   insert picks the lowest clear slot, and writes back the memories that the
//   request kind changes. The result appears on rsp with done high for exactly
//   one cycle, in the cycle after the execute cycle; the receiver cannot stall,
//   so it must take it then. No request is taken while one executes (busy
//   high), for the metadata memory is read, modified and written back; a new
//   request may transfer in the cycle done is high. slots_per_page is written
//   through cfg_valid/cfg_data (cfg_ready is always high); the user must write
//   it only while no request is in flight, as the block does not enforce it.
//   Reset: no pages open, page list empty, slots_per_page 32. The memories
//   are not cleared; a page's metadata is written when the page opens.
module record_slot_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rsa_pkg::req_t              req,
    output logic                       done,
    output rsa_pkg::rsp_t              rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rsa_pkg::SPP_W-1:0]  cfg_data
);

    rsa_pkg::state_t                    state_reg, state_next;
    logic [rsa_pkg::PAGE_CNT_W-1:0]     count_reg, count_next;
    logic [rsa_pkg::PAGE_CNT_W-1:0]     head_reg, head_next;
    logic [rsa_pkg::PAGES-1:0]          in_list_reg, in_list_next;
    logic [rsa_pkg::SPP_W-1:0]          spp_reg;
    logic                               done_reg, done_next;
    rsa_pkg::req_t                      req_reg;
    rsa_pkg::rsp_t                      rsp_reg, rsp_next;

    logic                               accept;
    logic                               exec;
    logic [rsa_pkg::SPP_W-1:0]          spp_eff;
    logic                               fresh_page;
    logic                               file_full;
    logic [rsa_pkg::PAGE_W-1:0]         ins_page;
    logic [rsa_pkg::PAGE_W-1:0]         meta_rd_addr;
    rsa_pkg::meta_t                     meta_rd;
    rsa_pkg::meta_t                     cur_meta;
    rsa_pkg::meta_wr_t                  meta_wr;
    rsa_pkg::rec_wr_t                   rec_wr;
    logic [rsa_pkg::RECORD_BITS-1:0]    rec_rd;
    logic                               slot_found;
    logic [rsa_pkg::SLOT_W-1:0]         free_slot;
    logic [rsa_pkg::SPP_W-1:0]          used_inc;
    logic [rsa_pkg::SLOTS-1:0]          ins_bit;
    logic [rsa_pkg::SLOTS-1:0]          del_bit;

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign exec      = (state_reg == rsa_pkg::ST_EXEC);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    // Clamp the configured page size into range
    always_comb
    begin
        if (spp_reg == '0)
        begin
            spp_eff = rsa_pkg::SPP_W'(1);
        end
        else if (spp_reg > rsa_pkg::SPP_W'(rsa_pkg::SLOTS))
        begin
            spp_eff = rsa_pkg::SPP_W'(rsa_pkg::SLOTS);
        end
        else
        begin
            spp_eff = spp_reg;
        end
    end

    // Select the page an insert works on: list head or a fresh page
    assign fresh_page = (head_reg == rsa_pkg::NO_PAGE);
    assign ins_page   = fresh_page ? count_reg[rsa_pkg::PAGE_W-1:0]
                                   : head_reg[rsa_pkg::PAGE_W-1:0];
    assign file_full  = fresh_page && (count_reg == rsa_pkg::PAGE_CNT_W'(rsa_pkg::PAGES));

    assign meta_rd_addr = (req.kind == rsa_pkg::KIND_INSERT) ? ins_page : req.page_number;

    rsa_meta_ram u_meta_ram (
        .clk     (clk),
        .wr      (meta_wr),
        .rd_en   (accept),
        .rd_addr (meta_rd_addr),
        .rd_data (meta_rd)
    );

    rsa_record_ram u_record_ram (
        .clk     (clk),
        .wr      (rec_wr),
        .rd_en   (accept),
        .rd_addr ({req.page_number, req.slot_number}),
        .rd_data (rec_rd)
    );

    // Substitute blank metadata for a page being opened
    always_comb
    begin
        if ((req_reg.kind == rsa_pkg::KIND_INSERT) && fresh_page)
        begin
            cur_meta.next_free  = rsa_pkg::NO_PAGE;
            cur_meta.used_count = '0;
            cur_meta.occupancy  = '0;
        end
        else
        begin
            cur_meta = meta_rd;
        end
    end

    rsa_slot_find u_slot_find (
        .occupancy (cur_meta.occupancy),
        .spp       (spp_eff),
        .found     (slot_found),
        .slot      (free_slot)
    );

    assign used_inc = cur_meta.used_count + rsa_pkg::SPP_W'(1);
    assign ins_bit  = {{(rsa_pkg::SLOTS-1){1'b0}}, 1'b1} << free_slot;
    assign del_bit  = {{(rsa_pkg::SLOTS-1){1'b0}}, 1'b1} << req_reg.slot_number;

    // Execute the request: check, modify metadata, write back, form result
    always_comb
    begin
        count_next   = count_reg;
        head_next    = head_reg;
        in_list_next = in_list_reg;
        meta_wr.en   = 1'b0;
        meta_wr.addr = (req_reg.kind == rsa_pkg::KIND_INSERT) ? ins_page
                                                              : req_reg.page_number;
        meta_wr.data = cur_meta;
        rec_wr.en    = 1'b0;
        rec_wr.addr  = {req_reg.page_number, req_reg.slot_number};
        rec_wr.data  = req_reg.record_data;
        rsp_next     = '0;

        if (exec)
        begin
            if (req_reg.kind == rsa_pkg::KIND_INSERT)
            begin
                if (file_full)
                begin
                    rsp_next.status = rsa_pkg::STATUS_FULL;
                end
                else
                begin
                    if (fresh_page)
                    begin
                        count_next = count_reg + rsa_pkg::PAGE_CNT_W'(1);
                        meta_wr.en = 1'b1;
                    end
                    if (!slot_found)
                    begin
                        // drop the head page that has no clear slot
                        head_next              = cur_meta.next_free;
                        in_list_next[ins_page] = 1'b0;
                        rsp_next.status        = rsa_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        meta_wr.en              = 1'b1;
                        meta_wr.data.occupancy  = cur_meta.occupancy | ins_bit;
                        meta_wr.data.used_count = used_inc;
                        rec_wr.en               = 1'b1;
                        rec_wr.addr             = {ins_page, free_slot};
                        rsp_next.status         = rsa_pkg::STATUS_OK;
                        rsp_next.result_page    = ins_page;
                        rsp_next.result_slot    = free_slot;
                        if (used_inc >= spp_eff)
                        begin
                            head_next              = cur_meta.next_free;
                            in_list_next[ins_page] = 1'b0;
                        end
                        else if (fresh_page)
                        begin
                            head_next              = {1'b0, ins_page};
                            in_list_next[ins_page] = 1'b1;
                        end
                    end
                end
            end
            else if ({1'b0, req_reg.page_number} >= count_reg)
            begin
                rsp_next.status = rsa_pkg::STATUS_NO_PAGE;
            end
            else if (({1'b0, req_reg.slot_number} >= spp_eff)
                     || !cur_meta.occupancy[req_reg.slot_number])
            begin
                rsp_next.status = rsa_pkg::STATUS_EMPTY;
            end
            else
            begin
                rsp_next.status = rsa_pkg::STATUS_OK;
                case (req_reg.kind)
                    rsa_pkg::KIND_DELETE:
                    begin
                        // relink a full page that left the list
                        if ((cur_meta.used_count >= spp_eff)
                            && !in_list_reg[req_reg.page_number])
                        begin
                            meta_wr.data.next_free            = head_reg;
                            head_next                         = {1'b0, req_reg.page_number};
                            in_list_next[req_reg.page_number] = 1'b1;
                        end
                        meta_wr.en             = 1'b1;
                        meta_wr.data.occupancy = cur_meta.occupancy & ~del_bit;
                        if (cur_meta.used_count != '0)
                        begin
                            meta_wr.data.used_count = cur_meta.used_count
                                                      - rsa_pkg::SPP_W'(1);
                        end
                    end
                    rsa_pkg::KIND_READ:
                    begin
                        rsp_next.read_data = rec_rd;
                    end
                    rsa_pkg::KIND_UPDATE:
                    begin
                        rec_wr.en = 1'b1;
                    end
                    default:
                    begin
                        rsp_next.status = rsa_pkg::STATUS_OK;
                    end
                endcase
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rsa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rsa_pkg::ST_EXEC;
                end
            end
            rsa_pkg::ST_EXEC:
            begin
                state_next = rsa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rsa_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        busy      = 1'b0;
        done_next = 1'b0;
        case (state_reg)
            rsa_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            rsa_pkg::ST_EXEC:
            begin
                busy      = 1'b1;
                done_next = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rsa_pkg::ST_IDLE;
            count_reg   <= '0;
            head_reg    <= rsa_pkg::NO_PAGE;
            in_list_reg <= '0;
            spp_reg     <= rsa_pkg::SPP_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            in_list_reg <= in_list_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                spp_reg <= cfg_data;
            end
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (exec)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // A result follows exactly one execute cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == rsa_pkg::ST_EXEC))
        else $error("result strobe without an execute cycle");

    // A transfer always starts an execute cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> exec)
        else $error("accepted request did not execute");

    // The list head is a page in the list or the empty mark
    a_head_listed: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != rsa_pkg::NO_PAGE) |->
            (in_list_reg[head_reg[rsa_pkg::PAGE_W-1:0]] && (head_reg < count_reg)))
        else $error("free list head not linked or not open");

    // Page counter never passes the file size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rsa_pkg::PAGE_CNT_W'(rsa_pkg::PAGES))
        else $error("page count out of range");

    // The page count changes only on an execute cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !exec |=> $stable(count_reg))
        else $error("page count changed outside execute");

endmodule
